[design/callsite_dedup_hash_table_assert.svh]
// Assertion macros for the call-site table.
`ifndef CALLSITE_DEDUP_HASH_TABLE_ASSERT_SVH
`define CALLSITE_DEDUP_HASH_TABLE_ASSERT_SVH
`ifndef SYNTH
`define CDH_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cdh assertion failed");
`define CDH_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cdh assertion failed");
`else
`define CDH_ASSERT_IMP(lbl, ante, cons)
`define CDH_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[design/cdh_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package cdh_pkg;
  // result status codes
  typedef enum logic [1:0] {
    ST_MATCH  = 2'd0,
    ST_NEW    = 2'd1,
    ST_REJECT = 2'd2
  } status_t;

  localparam logic [31:0] HASH_SEED      = 32'd5381;
  localparam int          ID_SHIFT       = 24;
  localparam logic [31:0] ID_STRIPE_MASK = 32'hFF;
  localparam logic [31:0] COUNT_MAX      = 32'hFFFF_FFFF;
endpackage
`default_nettype wire

[design/callsite_dedup_hash_table.sv]
`timescale 1ns / 1ps
`default_nettype none
// Call-site dedup table. Frames enter one per cycle on start while busy is low;
// a non-final frame leaves busy low. A final frame with capture disabled or no
// kept frame is rejected at once: busy stays low and the beat follows on the
// next cycle. Any other final frame raises busy: the hash is reduced to stripe
// and home slot by a masking remainder unit (STRIPES and SLOTS_PER_STRIPE must
// be powers of two), then each probed slot is read and checked, as is each
// compared frame, and an insert writes one frame per cycle after its beat. Each
// final frame yields exactly one beat on out_valid, held for one cycle only;
// the receiver cannot stall it. After reset the slot table is cleared one slot
// per cycle (all STRIPES*SLOTS_PER_STRIPE slots, 2048 by default) with busy
// high; cfg writes are taken at any time.
module callsite_dedup_hash_table #(
  parameter int STRIPES            = 4,
  parameter int MAX_FRAMES         = 16,
  parameter int ENTRIES_PER_STRIPE = 256,
  parameter int SLOTS_PER_STRIPE   = 512
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [63:0] in_frame_addr,
  input  wire logic        in_last_frame,
  input  wire logic        cfg_we,
  input  wire logic [4:0]  cfg_wdata,
  output logic             out_valid,
  output logic [25:0]      out_callsite_id,
  output logic [1:0]       out_status,
  output logic [31:0]      out_hit_count
);
  localparam int TOT_SLOTS = STRIPES * SLOTS_PER_STRIPE;
  localparam int TOT_ENT   = STRIPES * ENTRIES_PER_STRIPE;
  localparam int TOT_FR    = TOT_ENT * MAX_FRAMES;
  localparam int SW   = $clog2(ENTRIES_PER_STRIPE + 1);
  localparam int STW  = (STRIPES > 1) ? $clog2(STRIPES) : 1;
  localparam int SLW  = $clog2(SLOTS_PER_STRIPE);
  localparam int NW   = $clog2(SLOTS_PER_STRIPE + 1);
  localparam int PDW  = $clog2(MAX_FRAMES + 1);
  localparam int FW   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int SAW  = $clog2(TOT_SLOTS);
  localparam int EW   = (TOT_ENT > 1) ? $clog2(TOT_ENT) : 1;
  localparam int FAW  = (TOT_FR > 1) ? $clog2(TOT_FR) : 1;
  localparam int DMAX = (SLOTS_PER_STRIPE > STRIPES) ? SLOTS_PER_STRIPE : STRIPES;
  localparam int DW   = $clog2(DMAX + 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MODS_GO, S_MODS_WT, S_MODH_GO, S_MODH_WT,
    S_PROBE_RD, S_PROBE_CHK, S_CMP_RD, S_CMP_CHK, S_INS_FR
  } state_t;

  state_t           state_r;
  logic [4:0]       limit_r;
  logic [PDW-1:0]   pd_r;
  logic [31:0]      hash_r;
  logic [63:0]      pend_r [MAX_FRAMES];
  logic [STW-1:0]   stripe_r;
  logic [SLW-1:0]   slot_r;
  logic [NW-1:0]    n_r;
  logic [EW-1:0]    e_r;
  logic [SW-1:0]    idx1_r;
  logic [PDW-1:0]   f_r;
  logic [SAW-1:0]   clr_r;
  logic [SW-1:0]    fill_r [STRIPES];
  logic             out_valid_r;
  logic [25:0]      out_id_r;
  logic [1:0]       out_status_r;
  logic [31:0]      out_count_r;

  // memories
  logic [SW-1:0]    slot_mem  [TOT_SLOTS];
  logic [PDW-1:0]   depth_mem [TOT_ENT];
  logic [31:0]      count_mem [TOT_ENT];
  logic [63:0]      frame_mem [TOT_FR];
  logic [SW-1:0]    slot_q;
  logic [PDW-1:0]   depth_q;
  logic [31:0]      count_q;
  logic [63:0]      frame_q;

  logic [31:0]      hash_nxt;
  logic             keep;
  logic [PDW-1:0]   pd_inc;
  logic             mod_go;
  logic             mod_done;
  logic [DW-1:0]    mod_div;
  logic [DW-1:0]    mod_rem;
  logic [SAW-1:0]   slot_addr;
  logic [SW-1:0]    cur_fill;
  logic             can_ins;
  logic [EW-1:0]    ins_e;
  logic [EW-1:0]    hit_e;
  logic [FAW-1:0]   fr_addr;
  logic [63:0]      pend_f;
  logic             slot_we;
  logic [SAW-1:0]   slot_waddr;
  logic [SW-1:0]    slot_wdata;
  logic             ent_we;
  logic [EW-1:0]    ent_waddr;
  logic [31:0]      cnt_new;
  logic             cmp_hit;
  logic             cmp_last;
  logic [31:0]      id_word;
  logic [31:0]      id_new;

  // djb2 fold of the incoming frame
  assign hash_nxt = (hash_r << 5) + hash_r + in_frame_addr[31:0];
  assign keep     = (32'(pd_r) < 32'(limit_r)) && (32'(pd_r) < 32'(MAX_FRAMES));
  assign pd_inc   = keep ? pd_r + PDW'(1) : pd_r;

  // address arithmetic
  assign slot_addr = SAW'(32'(stripe_r) * 32'(SLOTS_PER_STRIPE) + 32'(slot_r));
  assign cur_fill  = fill_r[stripe_r];
  assign can_ins   = 32'(cur_fill) < 32'(ENTRIES_PER_STRIPE);
  assign ins_e     = EW'(32'(stripe_r) * 32'(ENTRIES_PER_STRIPE) + 32'(cur_fill));
  assign hit_e     = EW'(32'(stripe_r) * 32'(ENTRIES_PER_STRIPE) + 32'(slot_q) - 32'd1);
  assign fr_addr   = FAW'(32'(e_r) * 32'(MAX_FRAMES) + 32'(f_r));
  assign pend_f    = pend_r[f_r[FW-1:0]];
  assign cnt_new   = (count_q == cdh_pkg::COUNT_MAX) ? count_q : count_q + 32'd1;
  assign cmp_hit   = (depth_q == pd_r) && (frame_q == pend_f);
  assign cmp_last  = (f_r + PDW'(1)) == pd_r;
  assign id_word   = (32'(stripe_r) & cdh_pkg::ID_STRIPE_MASK) << cdh_pkg::ID_SHIFT;
  assign id_new    = id_word | (32'(cur_fill) + 32'd1);

  // remainder unit, shared by stripe and home slot
  assign mod_go  = (state_r == S_MODS_GO) || (state_r == S_MODH_GO);
  assign mod_div = (state_r == S_MODS_GO || state_r == S_MODS_WT) ?
                   DW'(STRIPES) : DW'(SLOTS_PER_STRIPE);

  cdh_mod_unit #(.DW(DW)) u_mod (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (mod_go),
    .value   (hash_r),
    .divisor (mod_div),
    .done    (mod_done),
    .rem     (mod_rem)
  );

  // memory write controls
  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = slot_addr;
    slot_wdata = cur_fill + SW'(1);
    ent_we     = 1'b0;
    ent_waddr  = e_r;
    if (state_r == S_CLEAR) begin
      slot_we    = 1'b1;
      slot_waddr = clr_r;
      slot_wdata = '0;
    end else if (state_r == S_PROBE_CHK && slot_q == '0 && can_ins) begin
      slot_we   = 1'b1;
      ent_we    = 1'b1;
      ent_waddr = ins_e;
    end else if (state_r == S_CMP_CHK && cmp_hit && cmp_last) begin
      ent_we = 1'b1;
    end
  end

  // slot table
  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    slot_q <= slot_mem[slot_addr];
  end

  // entry depth and count
  always_ff @(posedge clk) begin
    if (ent_we) begin
      depth_mem[ent_waddr] <= pd_r;
      count_mem[ent_waddr] <= (state_r == S_PROBE_CHK) ? 32'd1 : cnt_new;
    end
    depth_q <= depth_mem[e_r];
    count_q <= count_mem[e_r];
  end

  // entry frames
  always_ff @(posedge clk) begin
    if (state_r == S_INS_FR) begin
      frame_mem[fr_addr] <= pend_f;
    end
    frame_q <= frame_mem[fr_addr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      limit_r     <= 5'd16;
      pd_r        <= '0;
      hash_r      <= cdh_pkg::HASH_SEED;
      out_valid_r <= 1'b0;
      for (int i = 0; i < STRIPES; i++) begin
        fill_r[i] <= '0;
      end
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + SAW'(1);
          if (32'(clr_r) == TOT_SLOTS - 1) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            if (keep) begin
              pend_r[pd_r[FW-1:0]] <= in_frame_addr;
              hash_r               <= hash_nxt;
            end
            pd_r <= pd_inc;
            if (in_last_frame) begin
              if (limit_r == 5'd0 || pd_inc == '0) begin
                out_valid_r  <= 1'b1;
                out_id_r     <= '0;
                out_status_r <= cdh_pkg::ST_REJECT;
                out_count_r  <= '0;
                pd_r         <= '0;
                hash_r       <= cdh_pkg::HASH_SEED;
              end else begin
                state_r <= S_MODS_GO;
              end
            end
          end
        end
        S_MODS_GO: state_r <= S_MODS_WT;
        S_MODS_WT: begin
          if (mod_done) begin
            stripe_r <= STW'(mod_rem);
            state_r  <= S_MODH_GO;
          end
        end
        S_MODH_GO: state_r <= S_MODH_WT;
        S_MODH_WT: begin
          if (mod_done) begin
            slot_r  <= SLW'(mod_rem);
            n_r     <= '0;
            state_r <= S_PROBE_RD;
          end
        end
        S_PROBE_RD: state_r <= S_PROBE_CHK;
        S_PROBE_CHK: begin
          if (slot_q == '0) begin
            out_valid_r <= 1'b1;
            if (can_ins) begin
              // empty slot: insert new entry, frames follow
              out_id_r          <= id_new[25:0];
              out_status_r      <= cdh_pkg::ST_NEW;
              out_count_r       <= 32'd1;
              fill_r[stripe_r]  <= cur_fill + SW'(1);
              e_r               <= ins_e;
              f_r               <= '0;
              state_r           <= S_INS_FR;
            end else begin
              out_id_r     <= '0;
              out_status_r <= cdh_pkg::ST_REJECT;
              out_count_r  <= '0;
              pd_r         <= '0;
              hash_r       <= cdh_pkg::HASH_SEED;
              state_r      <= S_IDLE;
            end
          end else if (32'(slot_q) - 32'd1 < 32'(ENTRIES_PER_STRIPE)) begin
            e_r     <= hit_e;
            idx1_r  <= slot_q;
            f_r     <= '0;
            state_r <= S_CMP_RD;
          end else if (32'(n_r) == SLOTS_PER_STRIPE - 1) begin
            out_valid_r  <= 1'b1;
            out_id_r     <= '0;
            out_status_r <= cdh_pkg::ST_REJECT;
            out_count_r  <= '0;
            pd_r         <= '0;
            hash_r       <= cdh_pkg::HASH_SEED;
            state_r      <= S_IDLE;
          end else begin
            n_r     <= n_r + NW'(1);
            slot_r  <= (32'(slot_r) == SLOTS_PER_STRIPE - 1) ? '0 : slot_r + SLW'(1);
            state_r <= S_PROBE_RD;
          end
        end
        S_CMP_RD: state_r <= S_CMP_CHK;
        S_CMP_CHK: begin
          if (cmp_hit && cmp_last) begin
            out_valid_r  <= 1'b1;
            out_id_r     <= 26'(id_word | 32'(idx1_r));
            out_status_r <= cdh_pkg::ST_MATCH;
            out_count_r  <= cnt_new;
            pd_r         <= '0;
            hash_r       <= cdh_pkg::HASH_SEED;
            state_r      <= S_IDLE;
          end else if (cmp_hit) begin
            f_r     <= f_r + PDW'(1);
            state_r <= S_CMP_RD;
          end else if (32'(n_r) == SLOTS_PER_STRIPE - 1) begin
            // every slot probed, all occupied
            out_valid_r  <= 1'b1;
            out_id_r     <= '0;
            out_status_r <= cdh_pkg::ST_REJECT;
            out_count_r  <= '0;
            pd_r         <= '0;
            hash_r       <= cdh_pkg::HASH_SEED;
            state_r      <= S_IDLE;
          end else begin
            n_r     <= n_r + NW'(1);
            slot_r  <= (32'(slot_r) == SLOTS_PER_STRIPE - 1) ? '0 : slot_r + SLW'(1);
            state_r <= S_PROBE_RD;
          end
        end
        S_INS_FR: begin
          f_r <= f_r + PDW'(1);
          if (cmp_last) begin
            pd_r    <= '0;
            hash_r  <= cdh_pkg::HASH_SEED;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_callsite_id = out_id_r;
  assign out_status      = out_status_r;
  assign out_hit_count   = out_count_r;

`include "callsite_dedup_hash_table_assert.svh"
  // a rejected beat carries no id and no count
  `CDH_ASSERT_IMP(a_reject_zero, out_valid && out_status == cdh_pkg::ST_REJECT, out_callsite_id == 26'd0 && out_hit_count == 32'd0)
  // a matched or new entry never reports a zero count
  `CDH_ASSERT_IMP(a_hit_nonzero, out_valid && out_status != cdh_pkg::ST_REJECT, out_hit_count != 32'd0)
  // nothing leaves while the slot table is being cleared
  `CDH_ASSERT_NXT(a_clear_quiet, state_r == S_CLEAR, !out_valid)
  // a final frame that starts a lookup always ends with the block busy
  `CDH_ASSERT_NXT(a_lookup_busy, start && !busy && in_last_frame && !out_valid_r && keep && limit_r != 5'd0, busy || out_valid)
endmodule
`default_nettype wire

[design/cdh_mod_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// Power-of-two remainder: the low bits of the value under the divisor mask,
// ready in the cycle after go.
module cdh_mod_unit #(
  parameter int DW = 10
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          go,
  input  wire logic [31:0]   value,
  input  wire logic [DW-1:0] divisor,
  output logic               done,
  output logic [DW-1:0]      rem
);
  logic          done_r;
  logic [DW-1:0] rem_r;

  // divisor is a power of two, so the remainder is a mask of the low bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= go;
      if (go) begin
        rem_r <= value[DW-1:0] & (divisor - DW'(1));
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r;
endmodule
`default_nettype wire
